// ----- rtl/core/rtdc_pkg.sv -----
// rtdc_pkg: widths, constants, tables and types shared by the rtd code to temperature core
// no dependencies; imported by every module under rtl/core
`default_nettype none
package rtdc_pkg;

	localparam int CODE_W      = 15;
	localparam int CODE_BITS   = 15;
	localparam int R0_W        = 14;
	localparam int RREF_W      = 17;
	localparam int CFG_W       = 17;
	localparam int RATIO_SHIFT = 15;

	localparam int NUM_W  = CODE_BITS + RREF_W;
	localparam int DEN_W  = R0_W + RATIO_SHIFT;
	localparam int DVD_W  = DEN_W + 2;
	localparam int CMP_W  = (NUM_W > DVD_W) ? NUM_W : DVD_W;

	localparam int RDIV_STEPS = 32;
	localparam int Q_W        = 32;
	localparam int YQ_W       = 26;
	localparam int UQ_W       = 30;

	localparam int SQ_PROD_W  = 54;
	localparam int E_W        = 55;
	localparam int RAD_W      = 56;
	localparam int ROOT_W     = 28;
	localparam int SREM_W     = 30;
	localparam int SQRT_STEPS = 28;

	localparam int QNUM_W     = 47;
	localparam int QD_W       = 29;
	localparam int QT_W       = 20;
	localparam int QUOT_STEPS = 20;

	localparam int ACC_W  = 24;
	localparam int PP_W   = 55;
	localparam int MAG_W  = 28;
	localparam int RP_W   = 58;
	localparam int RSH    = 39;
	localparam int T_W    = 19;

	localparam int SQRT_LAT = SQRT_STEPS + 2;
	localparam int QUOT_LAT = QUOT_STEPS + 2;
	localparam int POLY_LAT = 14;
	localparam int POLY_PAD = SQRT_LAT + QUOT_LAT - POLY_LAT;

	localparam logic [R0_W-1:0]   R0_RESET   = 14'd1600;
	localparam logic [RREF_W-1:0] RREF_RESET = 17'd6880;

	localparam logic [E_W-1:0]    E_BASE      = 55'd1527480889 << 24;
	localparam logic [27:0]       FOUR_B_E14  = 28'd231000000;
	localparam logic [QD_W-1:0]   A_E7_Q12    = 29'd160083968;
	localparam logic [20:0]       T_SCALE     = 21'd1250000;
	localparam logic [29:0]       RECIP_1250  = 30'd439804652;
	localparam logic [MAG_W-1:0]  ROUND_HALF  = 28'd625;

	localparam logic signed [ACC_W-1:0] POLY_COEF [6] = '{
		-24'sd2420200, 24'sd2222800, 24'sd258590,
		-24'sd48260, -24'sd28183, 24'sd15243
	};

	localparam logic signed [T_W-1:0] T_MAX = 19'sd262143;
	localparam logic signed [T_W-1:0] T_MIN = -19'sd65536;

	typedef enum logic {
		REG_NOMINAL   = 1'b0,
		REG_REFERENCE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic den_zero;
		logic root;
		logic over;
	} path_t;

	typedef struct packed {
		logic signed [T_W-1:0] temp;
		logic                  poly;
		logic                  err;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/core/rtdc_ratio_div.sv -----
// rtdc_ratio_div: pipelined restoring divider, one quotient bit per stage
// gives floor(dividend * 2^30 / divisor); uses rtdc_pkg
`default_nettype none
module rtdc_ratio_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [rtdc_pkg::DVD_W-1:0]  dividend,
	input  logic [rtdc_pkg::DEN_W-1:0]  divisor,
	input  rtdc_pkg::path_t             in_path,
	output logic                        out_vld,
	output logic [rtdc_pkg::Q_W-1:0]    quotient,
	output rtdc_pkg::path_t             out_path
);
	import rtdc_pkg::*;

	logic [RDIV_STEPS:0] vld_s;
	logic [DEN_W-1:0]    rem_s  [RDIV_STEPS+1];
	logic [1:0]          lo_s   [RDIV_STEPS+1];
	logic [Q_W-1:0]      q_s    [RDIV_STEPS+1];
	logic [DEN_W-1:0]    den_s  [RDIV_STEPS+1];
	path_t               path_s [RDIV_STEPS+1];
	logic [DEN_W-1:0]    rem_n  [RDIV_STEPS];
	logic [Q_W-1:0]      q_n    [RDIV_STEPS];

	always_comb begin
		logic [DEN_W:0] remw;
		for (int k = 0; k < RDIV_STEPS; k++) begin
			remw = {rem_s[k], lo_s[k][1]};
			if (remw >= {1'b0, den_s[k]}) begin
				rem_n[k] = DEN_W'(remw - {1'b0, den_s[k]});
				q_n[k]   = {q_s[k][Q_W-2:0], 1'b1};
			end else begin
				rem_n[k] = remw[DEN_W-1:0];
				q_n[k]   = {q_s[k][Q_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[RDIV_STEPS-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= dividend[DVD_W-1:2];
			lo_s[0]   <= dividend[1:0];
			q_s[0]    <= '0;
			den_s[0]  <= divisor;
			path_s[0] <= in_path;
			for (int k = 0; k < RDIV_STEPS; k++) begin
				rem_s[k+1]  <= rem_n[k];
				lo_s[k+1]   <= {lo_s[k][0], 1'b0};
				q_s[k+1]    <= q_n[k];
				den_s[k+1]  <= den_s[k];
				path_s[k+1] <= path_s[k];
			end
		end
	end

	assign out_vld  = vld_s[RDIV_STEPS];
	assign quotient = q_s[RDIV_STEPS];
	assign out_path = path_s[RDIV_STEPS];

endmodule
`default_nettype wire

// ----- rtl/core/rtdc_sqrt.sv -----
// rtdc_sqrt: forms the quadratic root argument and takes its integer square root,
// two radicand bits per stage; uses rtdc_pkg
`default_nettype none
module rtdc_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic [rtdc_pkg::YQ_W-1:0]    yq,
	input  rtdc_pkg::path_t              in_path,
	output logic                         out_vld,
	output logic [rtdc_pkg::ROOT_W-1:0]  root,
	output logic [rtdc_pkg::YQ_W-1:0]    out_yq,
	output rtdc_pkg::path_t              out_path
);
	import rtdc_pkg::*;

	logic                 vld_sa;
	logic [SQ_PROD_W-1:0] prod_sa;
	logic [YQ_W-1:0]      yq_sa;
	path_t                path_sa;

	logic [SQRT_STEPS:0]  vld_s;
	logic [RAD_W-1:0]     rad_s  [SQRT_STEPS+1];
	logic [SREM_W-1:0]    rem_s  [SQRT_STEPS+1];
	logic [ROOT_W-1:0]    root_s [SQRT_STEPS+1];
	logic [YQ_W-1:0]      yq_s   [SQRT_STEPS+1];
	path_t                path_s [SQRT_STEPS+1];
	logic [SREM_W-1:0]    rem_n  [SQRT_STEPS];
	logic [ROOT_W-1:0]    root_n [SQRT_STEPS];

	always_comb begin
		logic [SREM_W+1:0] remw;
		logic [SREM_W+1:0] trial;
		for (int k = 0; k < SQRT_STEPS; k++) begin
			remw  = {rem_s[k], rad_s[k][RAD_W-1 -: 2]};
			trial = (SREM_W+2)'({root_s[k], 2'b01});
			if (remw >= trial) begin
				rem_n[k]  = SREM_W'(remw - trial);
				root_n[k] = {root_s[k][ROOT_W-2:0], 1'b1};
			end else begin
				rem_n[k]  = remw[SREM_W-1:0];
				root_n[k] = {root_s[k][ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
			vld_s  <= '0;
		end else if (en) begin
			vld_sa <= in_vld;
			vld_s  <= {vld_s[SQRT_STEPS-1:0], vld_sa};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_sa <= SQ_PROD_W'(FOUR_B_E14) * SQ_PROD_W'(yq);
			yq_sa   <= yq;
			path_sa <= in_path;

			rad_s[0]  <= {1'b0, E_BASE - {1'b0, prod_sa}};
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			yq_s[0]   <= yq_sa;
			path_s[0] <= path_sa;
			for (int k = 0; k < SQRT_STEPS; k++) begin
				rad_s[k+1]  <= {rad_s[k][RAD_W-3:0], 2'b00};
				rem_s[k+1]  <= rem_n[k];
				root_s[k+1] <= root_n[k];
				yq_s[k+1]   <= yq_s[k];
				path_s[k+1] <= path_s[k];
			end
		end
	end

	assign out_vld  = vld_s[SQRT_STEPS];
	assign root     = root_s[SQRT_STEPS];
	assign out_yq   = yq_s[SQRT_STEPS];
	assign out_path = path_s[SQRT_STEPS];

endmodule
`default_nettype wire

// ----- rtl/core/rtdc_quot.sv -----
// rtdc_quot: root path result, round(yq * 1250000 / (a + s)) by a pipelined
// restoring divider with one quotient bit per stage; uses rtdc_pkg
`default_nettype none
module rtdc_quot (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic [rtdc_pkg::YQ_W-1:0]    yq,
	input  logic [rtdc_pkg::ROOT_W-1:0]  root,
	input  rtdc_pkg::path_t              in_path,
	output logic                         out_vld,
	output logic [rtdc_pkg::QT_W-1:0]    quotient,
	output rtdc_pkg::path_t              out_path
);
	import rtdc_pkg::*;

	logic              vld_sa;
	logic [QNUM_W-1:0] prod_sa;
	logic [QD_W-1:0]   d_sa;
	path_t             path_sa;
	logic [QNUM_W-1:0] num_sa;

	logic [QUOT_STEPS:0] vld_s;
	logic [QD_W-1:0]     rem_s  [QUOT_STEPS+1];
	logic [QT_W-1:0]     lo_s   [QUOT_STEPS+1];
	logic [QT_W-1:0]     q_s    [QUOT_STEPS+1];
	logic [QD_W-1:0]     d_s    [QUOT_STEPS+1];
	path_t               path_s [QUOT_STEPS+1];
	logic [QD_W-1:0]     rem_n  [QUOT_STEPS];
	logic [QT_W-1:0]     q_n    [QUOT_STEPS];

	assign num_sa = prod_sa + QNUM_W'(d_sa >> 1);

	always_comb begin
		logic [QD_W:0] remw;
		for (int k = 0; k < QUOT_STEPS; k++) begin
			remw = {rem_s[k], lo_s[k][QT_W-1]};
			if (remw >= {1'b0, d_s[k]}) begin
				rem_n[k] = QD_W'(remw - {1'b0, d_s[k]});
				q_n[k]   = {q_s[k][QT_W-2:0], 1'b1};
			end else begin
				rem_n[k] = remw[QD_W-1:0];
				q_n[k]   = {q_s[k][QT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
			vld_s  <= '0;
		end else if (en) begin
			vld_sa <= in_vld;
			vld_s  <= {vld_s[QUOT_STEPS-1:0], vld_sa};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_sa <= QNUM_W'(yq) * QNUM_W'(T_SCALE);
			d_sa    <= A_E7_Q12 + QD_W'(root);
			path_sa <= in_path;

			rem_s[0]  <= QD_W'(num_sa[QNUM_W-1:QT_W]);
			lo_s[0]   <= num_sa[QT_W-1:0];
			q_s[0]    <= '0;
			d_s[0]    <= d_sa;
			path_s[0] <= path_sa;
			for (int k = 0; k < QUOT_STEPS; k++) begin
				rem_s[k+1]  <= rem_n[k];
				lo_s[k+1]   <= {lo_s[k][QT_W-2:0], 1'b0};
				q_s[k+1]    <= q_n[k];
				d_s[k+1]    <= d_s[k];
				path_s[k+1] <= path_s[k];
			end
		end
	end

	assign out_vld  = vld_s[QUOT_STEPS];
	assign quotient = q_s[QUOT_STEPS];
	assign out_path = path_s[QUOT_STEPS];

endmodule
`default_nettype wire

// ----- rtl/core/rtdc_poly.sv -----
// rtdc_poly: below-zero fifth-order polynomial, pipelined horner steps in q30,
// then scaling to 1/256 degree by a reciprocal multiply; uses rtdc_pkg
`default_nettype none
module rtdc_poly (
	input  logic                              clk,
	input  logic                              en,
	input  logic [rtdc_pkg::UQ_W-1:0]         uq,
	output logic signed [rtdc_pkg::T_W-1:0]   temp
);
	import rtdc_pkg::*;

	logic [UQ_W-1:0]          uq_s0;
	logic signed [PP_W-1:0]   prod_m [5];
	logic [UQ_W-1:0]          uq_m   [5];
	logic signed [ACC_W-1:0]  acc_a  [5];
	logic [UQ_W-1:0]          uq_a   [5];
	logic signed [PP_W-1:0]   prod_n [5];
	logic signed [ACC_W-1:0]  acc_n  [5];

	logic                     neg_f1;
	logic [MAG_W-1:0]         mag_f1;
	logic                     neg_f2;
	logic [RP_W-1:0]          prod_f2;
	logic signed [T_W-1:0]    temp_f3;
	logic signed [ACC_W-1:0]  abs_acc;

	always_comb begin
		logic signed [ACC_W-1:0] acc_in;
		logic [UQ_W-1:0]         uq_in;
		logic [ACC_W:0]          tr;
		for (int j = 0; j < 5; j++) begin
			acc_in    = (j == 0) ? POLY_COEF[5] : acc_a[(j == 0) ? 0 : j-1];
			uq_in     = (j == 0) ? uq_s0 : uq_a[(j == 0) ? 0 : j-1];
			prod_n[j] = acc_in * $signed({1'b0, uq_in});
			tr        = prod_m[j][PP_W-1:UQ_W]
				+ (ACC_W+1)'(prod_m[j][PP_W-1] & (|prod_m[j][UQ_W-1:0]));
			acc_n[j]  = ACC_W'(tr) + POLY_COEF[4-j];
		end
	end

	assign abs_acc = acc_a[4][ACC_W-1] ? -acc_a[4] : acc_a[4];

	always_ff @(posedge clk) begin
		if (en) begin
			uq_s0 <= uq;
			for (int j = 0; j < 5; j++) begin
				prod_m[j] <= prod_n[j];
				uq_m[j]   <= (j == 0) ? uq_s0 : uq_a[(j == 0) ? 0 : j-1];
				acc_a[j]  <= acc_n[j];
				uq_a[j]   <= uq_m[j];
			end
			neg_f1  <= acc_a[4][ACC_W-1];
			mag_f1  <= {abs_acc[MAG_W-6:0], 5'b00000} + ROUND_HALF;
			neg_f2  <= neg_f1;
			prod_f2 <= RP_W'(mag_f1) * RP_W'(RECIP_1250);
			temp_f3 <= neg_f2 ? -$signed(prod_f2[RP_W-1:RSH]) : $signed(prod_f2[RP_W-1:RSH]);
		end
	end

	assign temp = temp_f3;

endmodule
`default_nettype wire

// ----- rtl/core/rtdc_out_buf.sv -----
// rtdc_out_buf: two-entry result buffer between the pipeline and the output channel
// full comes from the registered count, so the pipeline enable does not see the output stall; uses rtdc_pkg
`default_nettype none
module rtdc_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rtdc_pkg::result_t push_data,
	input  logic              pop,
	output logic              full,
	output logic              valid,
	output rtdc_pkg::result_t head
);
	import rtdc_pkg::*;

	result_t    mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_data;
	end

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = mem[rd_ptr_q];

endmodule
`default_nettype wire

// ----- rtl/core/rtd_code_to_temperature.sv -----
// rtd_code_to_temperature: converter ratio code to temperature, callendar-van dusen
// depends on rtdc_pkg, rtdc_ratio_div, rtdc_sqrt, rtdc_quot, rtdc_poly, rtdc_out_buf
//
// usage:
//   input channel in_valid/in_stall carries raw_code; a transaction completes on a
//   rising edge with in_valid high and in_stall low. output channel out_valid/out_stall
//   carries temperature_q8, used_polynomial, domain_error, one result per code.
//   wr_en/wr_index/wr_data write nominal_resistance (0) or reference_resistance (1);
//   write only while no transaction is in flight.
//   throughput: one code per cycle while the output buffer is not full. the pipeline
//   length is set by the 32-stage ratio divider, the 28-stage square root and the
//   20-stage final divider in series.
//   reset clears all valid bits and loads 1600 and 6880 into the two registers.
//   a stalled output fills a two-entry buffer; when it is full the whole pipeline
//   holds and in_stall goes high, and nothing is lost or repeated.
`default_nettype none
module rtd_code_to_temperature (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  rtdc_pkg::reg_idx_t               wr_index,
	input  logic [rtdc_pkg::CFG_W-1:0]       wr_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [rtdc_pkg::CODE_W-1:0]      raw_code,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [rtdc_pkg::T_W-1:0]  temperature_q8,
	output logic                             used_polynomial,
	output logic                             domain_error
);
	import rtdc_pkg::*;

	logic [R0_W-1:0]   r0_q;
	logic [RREF_W-1:0] rref_q;

	logic              en;
	logic              buf_full;

	logic              vld_s1;
	logic [NUM_W-1:0]  num_s1;
	logic [DEN_W-1:0]  den_s1;

	logic              vld_s2;
	logic [DVD_W-1:0]  dvd_s2;
	logic [DEN_W-1:0]  den_s2;
	path_t             path_s2;

	logic [CMP_W-1:0]  num_x;
	logic [CMP_W-1:0]  den_x;
	logic [CMP_W-1:0]  yn;
	path_t             path_c;

	logic              rd_vld;
	logic [Q_W-1:0]    rd_q;
	path_t             rd_path;

	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	logic [YQ_W-1:0]   sq_yq;
	path_t             sq_path;

	logic              qt_vld;
	logic [QT_W-1:0]   qt_q;
	path_t             qt_path;

	logic signed [T_W-1:0] poly_temp;
	logic signed [T_W-1:0] pad_s [POLY_PAD];

	result_t           res;
	result_t           head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_q   <= R0_RESET;
			rref_q <= RREF_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_NOMINAL:   r0_q   <= wr_data[R0_W-1:0];
				REG_REFERENCE: rref_q <= wr_data[RREF_W-1:0];
			endcase
		end
	end

	assign en       = !buf_full;
	assign in_stall = buf_full;

	assign num_x = CMP_W'(num_s1);
	assign den_x = CMP_W'(den_s1);
	assign yn    = num_x - den_x;

	always_comb begin
		path_c.den_zero = (den_s1 == '0);
		path_c.root     = (num_x >= den_x);
		path_c.over     = (num_x >= den_x) && (yn >= CMP_W'({den_s1, 2'b00}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= NUM_W'(raw_code[CODE_BITS-1:0]) * NUM_W'(rref_q);
			den_s1  <= {r0_q, RATIO_SHIFT'(0)};
			dvd_s2  <= path_c.root ? DVD_W'(yn) : DVD_W'(num_x);
			den_s2  <= den_s1;
			path_s2 <= path_c;
		end
	end

	rtdc_ratio_div u_ratio_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.dividend (dvd_s2),
		.divisor  (den_s2),
		.in_path  (path_s2),
		.out_vld  (rd_vld),
		.quotient (rd_q),
		.out_path (rd_path)
	);

	rtdc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (rd_vld),
		.yq       (rd_q[Q_W-1:Q_W-YQ_W]),
		.in_path  (rd_path),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.out_yq   (sq_yq),
		.out_path (sq_path)
	);

	rtdc_quot u_quot (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (sq_vld),
		.yq       (sq_yq),
		.root     (sq_root),
		.in_path  (sq_path),
		.out_vld  (qt_vld),
		.quotient (qt_q),
		.out_path (qt_path)
	);

	rtdc_poly u_poly (
		.clk  (clk),
		.en   (en),
		.uq   (rd_q[UQ_W-1:0]),
		.temp (poly_temp)
	);

	// align the short polynomial path with the root path
	always_ff @(posedge clk) begin
		if (en) begin
			pad_s[0] <= poly_temp;
			for (int k = 0; k < POLY_PAD-1; k++) begin
				pad_s[k+1] <= pad_s[k];
			end
		end
	end

	always_comb begin
		res.temp = T_MAX;
		res.poly = 1'b0;
		res.err  = 1'b1;
		if (qt_path.den_zero || qt_path.over) begin
			res.temp = T_MAX;
			res.poly = 1'b0;
			res.err  = 1'b1;
		end else if (qt_path.root) begin
			res.poly = 1'b0;
			if (qt_q > QT_W'(T_MAX)) begin
				res.temp = T_MAX;
				res.err  = 1'b1;
			end else begin
				res.temp = $signed(T_W'(qt_q));
				res.err  = 1'b0;
			end
		end else begin
			res.poly = 1'b1;
			if (pad_s[POLY_PAD-1] < T_MIN) begin
				res.temp = T_MIN;
				res.err  = 1'b1;
			end else begin
				res.temp = pad_s[POLY_PAD-1];
				res.err  = 1'b0;
			end
		end
	end

	rtdc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (qt_vld && en),
		.push_data (res),
		.pop       (out_valid && !out_stall),
		.full      (buf_full),
		.valid     (out_valid),
		.head      (head)
	);

	assign temperature_q8  = head.temp;
	assign used_polynomial = head.poly;
	assign domain_error    = head.err;

endmodule
`default_nettype wire

// ----- verif/rtd_code_to_temperature_check.sv -----
// rtd_code_to_temperature_check: watches the config port and both channels of the block,
// predicts each temperature result and compares it field by field; depends on rtdc_pkg
`default_nettype none
module rtd_code_to_temperature_check (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  rtdc_pkg::reg_idx_t               wr_index,
	input  logic [rtdc_pkg::CFG_W-1:0]       wr_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [rtdc_pkg::CODE_W-1:0]      raw_code,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic signed [rtdc_pkg::T_W-1:0]  temperature_q8,
	input  logic                             used_polynomial,
	input  logic                             domain_error,
	output int                               pending,
	output int                               failures
);
	import rtdc_pkg::*;

	localparam longint TEMP_HI = 262143;
	localparam longint TEMP_LO = -65536;

	logic [R0_W-1:0]   nominal;
	logic [RREF_W-1:0] reference;
	result_t           temps_due[$];

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint scale_q30(input longint a, input longint unsigned uq);
		longint p;
		p = a * longint'(uq);
		if (p >= 0) return p >>> 30;
		return -((-p) >>> 30);
	endfunction

	function automatic result_t temp_from_code(input logic [CODE_W-1:0] code,
			input logic [R0_W-1:0] r0, input logic [RREF_W-1:0] rref);
		longint unsigned num, den, yn, yq, e, d, uq;
		longint t8, acc, n;
		longint coef[6];
		result_t res;
		coef = '{-2420200, 2222800, 258590, -48260, -28183, 15243};
		num = longint'(code) * longint'(rref);
		den = 64'd32768 * longint'(r0);
		res.poly = 1'b0;
		res.err = 1'b0;
		if (den == 0) begin
			t8 = TEMP_HI;
			res.err = 1'b1;
		end else if (num >= den) begin
			yn = num - den;
			if (yn >= 4 * den) begin
				t8 = TEMP_HI;
				res.err = 1'b1;
			end else begin
				yq = (yn << 24) / den;
				e = (64'd1527480889 << 24) - 64'd231000000 * yq;
				d = 64'd160083968 + int_sqrt(e);
				t8 = longint'((yq * 64'd1250000 + d / 2) / d);
			end
		end else begin
			uq = (num << 30) / den;
			acc = coef[5];
			for (int k = 4; k >= 0; k--) acc = scale_q30(acc, uq) + coef[k];
			n = acc * 32;
			if (n >= 0) t8 = (n + 625) / 1250;
			else t8 = -((-n + 625) / 1250);
			res.poly = 1'b1;
		end
		if (t8 > TEMP_HI) begin
			t8 = TEMP_HI;
			res.err = 1'b1;
		end
		if (t8 < TEMP_LO) begin
			t8 = TEMP_LO;
			res.err = 1'b1;
		end
		res.temp = t8[T_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		int bad;
		bad = 0;
		if (!arst_n) begin
			nominal <= R0_RESET;
			reference <= RREF_RESET;
			failures <= 0;
			pending <= 0;
		end else begin
			if (wr_en) begin
				if (wr_index == REG_NOMINAL) nominal <= wr_data[R0_W-1:0];
				else reference <= wr_data[RREF_W-1:0];
			end
			if (in_valid && !in_stall)
				temps_due.push_back(temp_from_code(raw_code, nominal, reference));
			if (out_valid && !out_stall) begin
				if (temps_due.size() == 0) begin
					$error("result transaction with nothing expected: temp %0d", temperature_q8);
					bad = bad + 1;
				end else begin
					want = temps_due.pop_front();
					if (temperature_q8 !== want.temp) begin
						$error("temperature_q8 expected %0d actual %0d", want.temp, temperature_q8);
						bad = bad + 1;
					end
					if (used_polynomial !== want.poly) begin
						$error("used_polynomial expected %0b actual %0b", want.poly,
							used_polynomial);
						bad = bad + 1;
					end
					if (domain_error !== want.err) begin
						$error("domain_error expected %0b actual %0b", want.err, domain_error);
						bad = bad + 1;
					end
				end
			end
			failures <= failures + bad;
			pending <= temps_due.size();
		end
	end

endmodule
`default_nettype wire

// ----- verif/rtd_code_to_temperature_test.sv -----
// rtd_code_to_temperature_test: clock, reset, config writes and code stimulus for the block
// depends on rtdc_pkg, rtd_code_to_temperature and rtd_code_to_temperature_check
`default_nettype none
module rtd_code_to_temperature_test;
	import rtdc_pkg::*;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      wr_en = 1'b0;
	reg_idx_t                  wr_index = REG_NOMINAL;
	logic [CFG_W-1:0]          wr_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [CODE_W-1:0]         raw_code = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [T_W-1:0]     temperature_q8;
	logic                      used_polynomial;
	logic                      domain_error;
	int                        pending;
	int                        failures;
	int                        send_idle_pct = 0;
	int                        stall_pct = 0;
	int                        hold_cycles = 0;
	bit                        hold_req = 1'b0;
	int                        cycles = 0;

	rtd_code_to_temperature dut (.*);
	rtd_code_to_temperature_check check (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("rtd_code_to_temperature_test failed");
			$finish;
		end
	end

	// receiver side; a hold-off request keeps it stalled for a long stretch
	always @(posedge clk) begin
		if (hold_req && hold_cycles == 0) begin
			hold_cycles <= 400;
			out_stall <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= (hold_cycles > 1);
			if (hold_cycles == 1) hold_req = 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_code(input logic [CODE_W-1:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_code <= c;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] v);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		@(posedge clk);
	endtask

	task automatic set_resistors(input int r0, input int rref);
		drain();
		write_reg(REG_NOMINAL, CFG_W'(r0));
		write_reg(REG_REFERENCE, CFG_W'(rref));
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input int r0, input int rref, input int idx, input int count);
		int pivot;
		set_resistors(r0, rref);
		case (idx % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 50; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 50; end
			default: begin send_idle_pct = 25; stall_pct = 25; end
		endcase
		if (idx == 2) hold_req = 1'b1;
		// code that lands near a ratio of one, where the two paths meet
		pivot = (rref == 0) ? 0 : (32768 * r0) / rref;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0 && pivot < 32768 - 64)
				send_code(CODE_W'(pivot + $urandom_range(64) - ((pivot > 64) ? 32 : 0)));
			else
				send_code(CODE_W'($urandom_range(32767)));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults, field extremes and alternating bits
		send_code(15'd0);
		send_code(15'd1);
		send_code(15'd32767);
		send_code(15'd16384);
		send_code(15'h5555);
		send_code(15'h2aaa);
		send_code(15'd7620);
		send_code(15'd7621);
		// ratio exactly one and the five-times boundary
		set_resistors(1600, 32768);
		send_code(15'd1599);
		send_code(15'd1600);
		send_code(15'd1601);
		send_code(15'd7999);
		send_code(15'd8000);
		send_code(15'd8001);
		// zero nominal resistance
		set_resistors(0, 6880);
		send_code(15'd0);
		send_code(15'd12345);
		// deep below zero and far above range
		set_resistors(16383, 16);
		send_code(15'd32767);
		send_code(15'd1);
		set_resistors(16, 131071);
		send_code(15'd0);
		send_code(15'd1);
		send_code(15'd32767);

		random_phase(1600, 6880, 0, 200);
		random_phase(16383, 131071, 1, 180);
		random_phase(1600, 6880, 2, 200);
		random_phase(16, 16, 3, 160);
		random_phase(16383, 16, 4, 160);
		random_phase(16, 131071, 5, 160);
		random_phase(0, 100000, 6, 40);
		random_phase($urandom_range(16383, 16), $urandom_range(131071, 16), 7, 200);
		random_phase(1600, 4300, 8, 180);
		random_phase($urandom_range(4000, 16), $urandom_range(40000, 16), 9, 150);

		drain();
		if (failures == 0) begin
			$display("rtd_code_to_temperature_test passed");
		end else begin
			$display("rtd_code_to_temperature_test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
